// ===== hw/rtl/vna_pkg.sv =====
// vna_pkg: shared types and constants of the vertex normal accumulator
// no dependencies; imported by every module of the block

package vna_pkg;

	localparam int IN_W     = 88;
	localparam int OUT_W    = 64;
	localparam int IDX_W    = 10;
	localparam int CRD_W    = 16;
	localparam int EDGE_W   = 17;
	localparam int NRM_W    = 38;
	localparam int MUL_W    = 33;
	localparam int PROD_W   = 66;
	localparam int SQ_W     = 62;
	localparam int S2_W     = 64;
	localparam int Q_W      = 15;
	localparam int ROOT_W   = 96;
	localparam int BIT_W    = 4;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_TRI  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic signed [CRD_W-1:0] UP_ONE = 16'sd32767;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TRD0,
		ST_TRD1,
		ST_TRD2,
		ST_TEDGE,
		ST_TMUL,
		ST_SRD,
		ST_SWR,
		ST_RRD,
		ST_RMAG,
		ST_RSHIFT,
		ST_RSQ,
		ST_RROOT,
		ST_RWAIT,
		ST_ROUT
	} st_t;

endpackage

// ===== hw/rtl/vna_mul.sv =====
// vna_mul: shared signed multiplier with registered product
// depends on vna_pkg

module vna_mul import vna_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

// ===== hw/rtl/vna_root.sv =====
// vna_root: bit-serial search for the largest q with q*q*s2 <= a2*2^30
// depends on vna_pkg

module vna_root import vna_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [SQ_W-1:0] a2,
	input  logic [S2_W-1:0] s2,
	output logic            done_q,
	output logic [Q_W-1:0]  q_q
);

	logic              busy_q;
	logic [BIT_W-1:0]  bit_q;
	logic [ROOT_W-1:0] p_q;
	logic [ROOT_W-1:0] qs_q;
	logic [ROOT_W-1:0] s_w;
	logic [ROOT_W-1:0] r_w;
	logic [ROOT_W-1:0] cand;
	logic              take;

	assign s_w  = {{(ROOT_W-S2_W){1'b0}}, s2};
	assign r_w  = {{(ROOT_W-SQ_W-30){1'b0}}, a2, 30'b0};
	assign cand = p_q + (qs_q << (bit_q + 1'b1)) + (s_w << {bit_q, 1'b0});
	assign take = (cand <= r_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q   <= '0;
			qs_q  <= '0;
			q_q   <= '0;
			bit_q <= BIT_W'(Q_W - 1);
		end else if (busy_q) begin
			if (take) begin
				p_q        <= cand;
				qs_q       <= qs_q + (s_w << bit_q);
				q_q[bit_q] <= 1'b1;
			end
			bit_q <= bit_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/vertex_normal_accumulator.sv =====
// vertex_normal_accumulator: top level, sequencer, position and sum memories
// depends on vna_pkg, vna_mul and vna_root
//
// usage: items arrive on the s_axis channel, action in tuser. a load stores a
// vertex position and clears its sum as it is accepted. a triangle reads
// three positions, forms the cross product over six passes of the shared
// multiplier and updates the three corner sums. a read takes magnitudes,
// shifts them below 2^31 (one bit a cycle), squares them on the multiplier
// and runs the 15-step root search three times. a zero sum skips to the
// output. the result goes to a one-entry output register on m_axis; the
// block keeps taking items while it waits, and a read stalls only when it
// must deliver into a full register. after reset the sum memory is cleared
// one entry a cycle, with s_axis_tready low.

module vertex_normal_accumulator import vna_pkg::*; #(
	parameter int VERTICES = 1024,
	parameter int SUM_BITS = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // vertex index, pos_x, pos_y, pos_z, corner_a/b/c
	input  logic [1:0]       s_axis_tuser,  // action
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // normal_vertex, normal_x, normal_y, normal_z, zeros
	output logic             m_axis_tuser   // degenerate
);

	localparam int IW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int AW = SUM_BITS + 2;
	localparam logic signed [AW-1:0] SMAX = {{(AW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [AW-1:0] SMIN = ~SMAX;

	st_t state_q, state_d;

	logic [IDX_W-1:0] in_vi, in_ca, in_cb, in_cc;
	logic             accept;
	logic             vi_ok, tri_ok;

	logic [3*CRD_W-1:0]    pos_mem [VERTICES];
	logic [3*SUM_BITS-1:0] sum_mem [VERTICES];
	logic [3*CRD_W-1:0]    pos_rd_q;
	logic [3*SUM_BITS-1:0] sum_rd_q;
	logic [IW-1:0]         pos_ra, sum_ra, sum_wa;
	logic [3*SUM_BITS-1:0] sum_wd;
	logic                  sum_we;

	logic [IW-1:0]    clr_q;
	logic [2:0]       cnt_q;
	logic [IDX_W-1:0] vi_q;
	logic [IW-1:0]    ca_q, cb_q, cc_q;
	logic [IW-1:0]    corner;

	logic signed [CRD_W-1:0]  pa_q [3];
	logic signed [EDGE_W-1:0] e1_q [3];
	logic signed [EDGE_W-1:0] e2_q [3];
	logic signed [NRM_W-1:0]  n_q  [3];

	logic [SUM_BITS-1:0] mag_q [3];
	logic                neg_q [3];
	logic [SQ_W-1:0]     a2_q  [3];
	logic [S2_W-1:0]     s2_q;
	logic [Q_W-1:0]      qv_q  [3];
	logic                deg_q;

	logic signed [MUL_W-1:0]  op_a, op_b;
	logic signed [PROD_W-1:0] prod_q;
	logic                     root_start, root_done;
	logic [Q_W-1:0]           root_q;
	logic                     out_load, out_free;
	logic [SUM_BITS-1:0]      any_mag;

	logic signed [CRD_W-1:0] out_n [3];

	function automatic logic signed [EDGE_W-1:0] crd(input logic [3*CRD_W-1:0] p,
		input int i);
		logic signed [CRD_W-1:0] c;
		c = p[i*CRD_W +: CRD_W];
		return EDGE_W'(c);
	endfunction

	function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
		input logic signed [NRM_W-1:0] n);
		logic signed [AW-1:0] t;
		t = AW'($signed(s)) + AW'(n);
		if (t > SMAX)
			return SMAX[SUM_BITS-1:0];
		else if (t < SMIN)
			return SMIN[SUM_BITS-1:0];
		return t[SUM_BITS-1:0];
	endfunction

	function automatic logic [SUM_BITS-1:0] mag(input logic [SUM_BITS-1:0] s);
		return s[SUM_BITS-1] ? (~s + 1'b1) : s;
	endfunction

	assign in_vi  = s_axis_tdata[9:0];
	assign in_ca  = s_axis_tdata[67:58];
	assign in_cb  = s_axis_tdata[77:68];
	assign in_cc  = s_axis_tdata[87:78];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign vi_ok  = 32'(in_vi) < VERTICES;
	assign tri_ok = (32'(in_ca) < VERTICES) && (32'(in_cb) < VERTICES)
		&& (32'(in_cc) < VERTICES);
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign any_mag  = mag_q[0] | mag_q[1] | mag_q[2];

	always_comb begin
		case (cnt_q)
			3'd0:    corner = ca_q;
			3'd1:    corner = cb_q;
			default: corner = cc_q;
		endcase
	end

	vna_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	vna_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.a2     (a2_q[cnt_q[1:0]]),
		.s2     (s2_q),
		.done_q (root_done),
		.q_q    (root_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		pos_ra        = cc_q;
		sum_ra        = IW'(vi_q);
		sum_we        = 1'b0;
		sum_wa        = clr_q;
		sum_wd        = '0;
		root_start    = 1'b0;
		out_load      = 1'b0;
		op_a          = '0;
		op_b          = '0;
		case (state_q)
			ST_CLEAR: begin
				sum_we = 1'b1;
				if (clr_q == IW'(VERTICES - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				sum_wa        = IW'(in_vi);
				if (accept) begin
					case (s_axis_tuser)
						ACT_LOAD: sum_we = vi_ok;
						ACT_TRI:  if (tri_ok) state_d = ST_TRD0;
						ACT_READ: state_d = vi_ok ? ST_RRD : ST_ROUT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_TRD0: begin
				pos_ra  = ca_q;
				state_d = ST_TRD1;
			end
			ST_TRD1: begin
				pos_ra  = cb_q;
				state_d = ST_TRD2;
			end
			ST_TRD2: state_d = ST_TEDGE;
			ST_TEDGE: state_d = ST_TMUL;
			ST_TMUL: begin
				case (cnt_q)
					3'd0: begin op_a = MUL_W'(e1_q[1]); op_b = MUL_W'(e2_q[2]); end
					3'd1: begin op_a = MUL_W'(e1_q[2]); op_b = MUL_W'(e2_q[1]); end
					3'd2: begin op_a = MUL_W'(e1_q[2]); op_b = MUL_W'(e2_q[0]); end
					3'd3: begin op_a = MUL_W'(e1_q[0]); op_b = MUL_W'(e2_q[2]); end
					3'd4: begin op_a = MUL_W'(e1_q[0]); op_b = MUL_W'(e2_q[1]); end
					3'd5: begin op_a = MUL_W'(e1_q[1]); op_b = MUL_W'(e2_q[0]); end
					default: begin op_a = '0; op_b = '0; end
				endcase
				if (cnt_q == 3'd6)
					state_d = ST_SRD;
			end
			ST_SRD: begin
				sum_ra  = corner;
				state_d = ST_SWR;
			end
			ST_SWR: begin
				sum_we = 1'b1;
				sum_wa = corner;
				sum_wd = {sat_add(sum_rd_q[2*SUM_BITS +: SUM_BITS], n_q[2]),
					sat_add(sum_rd_q[SUM_BITS +: SUM_BITS], n_q[1]),
					sat_add(sum_rd_q[0 +: SUM_BITS], n_q[0])};
				state_d = (cnt_q == 3'd2) ? ST_IDLE : ST_SRD;
			end
			ST_RRD: state_d = ST_RMAG;
			ST_RMAG: state_d = (sum_rd_q == '0) ? ST_ROUT : ST_RSHIFT;
			ST_RSHIFT: begin
				if ((any_mag >> 31) == '0)
					state_d = ST_RSQ;
			end
			ST_RSQ: begin
				if (cnt_q < 3'd3) begin
					op_a = {2'b0, mag_q[cnt_q[1:0]][30:0]};
					op_b = {2'b0, mag_q[cnt_q[1:0]][30:0]};
				end
				if (cnt_q == 3'd3)
					state_d = ST_RROOT;
			end
			ST_RROOT: begin
				root_start = 1'b1;
				state_d    = ST_RWAIT;
			end
			ST_RWAIT: begin
				if (root_done)
					state_d = (cnt_q == 3'd2) ? ST_ROUT : ST_RROOT;
			end
			ST_ROUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		pos_rd_q <= pos_mem[pos_ra];
		sum_rd_q <= sum_mem[sum_ra];
		if (accept && s_axis_tuser == ACT_LOAD && vi_ok)
			pos_mem[IW'(in_vi)] <= s_axis_tdata[57:10];
		if (sum_we)
			sum_mem[sum_wa] <= sum_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			case (state_q)
				ST_TMUL:  cnt_q <= (cnt_q == 3'd6) ? 3'd0 : cnt_q + 1'b1;
				ST_SWR:   cnt_q <= (cnt_q == 3'd2) ? 3'd0 : cnt_q + 1'b1;
				ST_RSQ:   cnt_q <= (cnt_q == 3'd3) ? 3'd0 : cnt_q + 1'b1;
				ST_RWAIT: if (root_done) cnt_q <= cnt_q + 1'b1;
				ST_SRD, ST_RROOT: cnt_q <= cnt_q;
				default:  cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					vi_q  <= in_vi;
					ca_q  <= IW'(in_ca);
					cb_q  <= IW'(in_cb);
					cc_q  <= IW'(in_cc);
					deg_q <= 1'b1;
				end
			end
			ST_TRD1: begin
				for (int i = 0; i < 3; i++)
					pa_q[i] <= pos_rd_q[i*CRD_W +: CRD_W];
			end
			ST_TRD2: begin
				for (int i = 0; i < 3; i++)
					e1_q[i] <= crd(pos_rd_q, i) - EDGE_W'(pa_q[i]);
			end
			ST_TEDGE: begin
				for (int i = 0; i < 3; i++)
					e2_q[i] <= crd(pos_rd_q, i) - EDGE_W'(pa_q[i]);
			end
			ST_TMUL: begin
				if (cnt_q != 3'd0) begin
					if (cnt_q[0])
						n_q[cnt_q[2:1]] <= prod_q[NRM_W-1:0];
					else
						n_q[cnt_q[2:1] - 1'b1] <= n_q[cnt_q[2:1] - 1'b1]
							- prod_q[NRM_W-1:0];
				end
			end
			ST_RMAG: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= mag(sum_rd_q[i*SUM_BITS +: SUM_BITS]);
					neg_q[i] <= sum_rd_q[i*SUM_BITS + SUM_BITS - 1];
				end
				deg_q <= (sum_rd_q == '0);
			end
			ST_RSHIFT: begin
				if ((any_mag >> 31) != '0) begin
					for (int i = 0; i < 3; i++)
						mag_q[i] <= mag_q[i] >> 1;
				end
			end
			ST_RSQ: begin
				if (cnt_q != 3'd0) begin
					a2_q[cnt_q[1:0] - 1'b1] <= prod_q[SQ_W-1:0];
					if (cnt_q == 3'd1)
						s2_q <= S2_W'(prod_q[SQ_W-1:0]);
					else
						s2_q <= s2_q + S2_W'(prod_q[SQ_W-1:0]);
				end
			end
			ST_RWAIT: begin
				if (root_done)
					qv_q[cnt_q[1:0]] <= root_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			out_n[i] = neg_q[i] ? -$signed({1'b0, qv_q[i]}) : $signed({1'b0, qv_q[i]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (out_load)
			m_axis_tvalid <= 1'b1;
		else if (m_axis_tready)
			m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tuser <= deg_q;
			if (deg_q)
				m_axis_tdata <= {6'b0, 16'sd0, UP_ONE, 16'sd0, vi_q};
			else
				m_axis_tdata <= {6'b0, out_n[2], out_n[1], out_n[0], vi_q};
		end
	end

endmodule

// ===== verif/tb_vertex_normal_accumulator.sv =====
`timescale 1ns / 1ps
// tb_vertex_normal_accumulator: stream testbench of the vertex normal accumulator
// depends on vna_pkg and vertex_normal_accumulator; self-contained predictor

module tb_vertex_normal_accumulator;
	import vna_pkg::*;

	localparam int NV = 1024;
	localparam int SB = 48;
	localparam int WATCHDOG = 20000;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [9:0]  vtx;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic        degen;
	} normal_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	vertex_normal_accumulator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	logic signed [15:0] px [NV];
	logic signed [15:0] py [NV];
	logic signed [15:0] pz [NV];
	logic signed [63:0] acc_x [NV];
	logic signed [63:0] acc_y [NV];
	logic signed [63:0] acc_z [NV];
	bit loaded [NV];

	normal_t normals_due[$];
	int mismatches;
	int checked;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	function automatic logic signed [63:0] sat_sum(logic signed [63:0] s, logic signed [63:0] n);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (SB - 1)) - 1;
		lo = -hi - 1;
		if (n > 0 && s > hi - n)
			return hi;
		if (n < 0 && s < lo - n)
			return lo;
		return s + n;
	endfunction

	// largest q with q*q*s2 <= a*a*2^30
	function automatic logic [14:0] unit_len(logic [63:0] a, logic [63:0] s2);
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [14:0] q;
		logic [14:0] c;
		rhs = {64'd0, a * a} << 30;
		q = 0;
		for (int b = 14; b >= 0; b--) begin
			c = q | (15'd1 << b);
			lhs = {98'd0, c} * {98'd0, c} * {64'd0, s2};
			if (lhs <= rhs)
				q = c;
		end
		return q;
	endfunction

	function automatic logic [15:0] with_sign(logic signed [63:0] s, logic [14:0] q);
		return s < 0 ? -{1'b0, q} : {1'b0, q};
	endfunction

	task automatic predict_normal(int v);
		normal_t r;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] az;
		logic [63:0] m;
		logic [63:0] s2;
		r.vtx = v[9:0];
		if (acc_x[v] == 0 && acc_y[v] == 0 && acc_z[v] == 0) begin
			r.nx = 0; r.ny = UP_ONE; r.nz = 0; r.degen = 1;
		end else begin
			ax = acc_x[v] < 0 ? -acc_x[v] : acc_x[v];
			ay = acc_y[v] < 0 ? -acc_y[v] : acc_y[v];
			az = acc_z[v] < 0 ? -acc_z[v] : acc_z[v];
			m = ax;
			if (ay > m) m = ay;
			if (az > m) m = az;
			while (m >= 64'h8000_0000) begin
				m >>= 1; ax >>= 1; ay >>= 1; az >>= 1;
			end
			s2 = ax * ax + ay * ay + az * az;
			r.nx = with_sign(acc_x[v], unit_len(ax, s2));
			r.ny = with_sign(acc_y[v], unit_len(ay, s2));
			r.nz = with_sign(acc_z[v], unit_len(az, s2));
			r.degen = 0;
		end
		normals_due = {normals_due, r};
	endtask

	task automatic apply_item(logic [1:0] act, int vi, logic [15:0] x, logic [15:0] y,
			logic [15:0] z, int ca, int cb, int cc);
		logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
		int cs[3];
		if (act == ACT_LOAD) begin
			px[vi] = x; py[vi] = y; pz[vi] = z;
			acc_x[vi] = 0; acc_y[vi] = 0; acc_z[vi] = 0;
			loaded[vi] = 1;
		end else if (act == ACT_TRI) begin
			e1x = px[cb] - px[ca]; e1y = py[cb] - py[ca]; e1z = pz[cb] - pz[ca];
			e2x = px[cc] - px[ca]; e2y = py[cc] - py[ca]; e2z = pz[cc] - pz[ca];
			nx = e1y * e2z - e1z * e2y;
			ny = e1z * e2x - e1x * e2z;
			nz = e1x * e2y - e1y * e2x;
			cs = '{ca, cb, cc};
			foreach (cs[i]) begin
				acc_x[cs[i]] = sat_sum(acc_x[cs[i]], nx);
				acc_y[cs[i]] = sat_sum(acc_y[cs[i]], ny);
				acc_z[cs[i]] = sat_sum(acc_z[cs[i]], nz);
			end
		end else if (act == ACT_READ) begin
			predict_normal(vi);
		end
	endtask

	task automatic send_item(logic [1:0] act, int vi, logic [15:0] x, logic [15:0] y,
			logic [15:0] z, int ca, int cb, int cc);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tuser <= act;
		s_axis_tdata <= {cc[9:0], cb[9:0], ca[9:0], z, y, x, vi[9:0]};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		apply_item(act, vi, x, y, z, ca, cb, cc);
		@(negedge clk);
	endtask

	function automatic int loaded_vertex();
		int v;
		v = $urandom_range(NV - 1);
		while (!loaded[v])
			v = $urandom_range(NV - 1);
		return v;
	endfunction

	task automatic send_load(int v, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		send_item(ACT_LOAD, v, x, y, z, $urandom, $urandom, $urandom);
	endtask

	task automatic send_tri(int a, int b, int c);
		send_item(ACT_TRI, $urandom, rnd16(), rnd16(), rnd16(), a, b, c);
	endtask

	task automatic send_read(int v);
		send_item(ACT_READ, v, rnd16(), rnd16(), rnd16(), $urandom, $urandom, $urandom);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (normals_due.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	always @(posedge clk) begin
		normal_t got;
		normal_t exp_n;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[9:0], m_axis_tdata[25:10], m_axis_tdata[41:26],
				m_axis_tdata[57:42], m_axis_tuser};
			if (normals_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected normal transfer %h", got);
			end else begin
				exp_n = normals_due.pop_front();
				checked++;
				if (got !== exp_n || m_axis_tdata[63:58] !== 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("normal mismatch: exp v%0d %h %h %h d%b got v%0d %h %h %h d%b",
							exp_n.vtx, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degen,
							got.vtx, got.nx, got.ny, got.nz, got.degen);
				end
			end
		end
	end

	always @(negedge clk)
		m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("watchdog expired");
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic test_extremes();
		send_read(5);
		send_load(0, 16'h8000, 16'h8000, 16'h8000);
		send_load(1, 16'h7fff, 16'h8000, 16'h8000);
		send_load(2, 16'h8000, 16'h7fff, 16'h7fff);
		send_read(0);
		send_tri(0, 1, 2);
		send_read(0); send_read(1); send_read(2);
		repeat (200) send_tri(0, 1, 2);
		send_read(0);
		send_tri(2, 1, 0);
		send_read(1);
		send_load(1023, 16'h0100, 16'h0000, 16'h0000);
		send_load(3, 16'h0000, 16'h0000, 16'h0000);
		send_load(4, 16'h0000, 16'h0100, 16'h0000);
		send_tri(3, 1023, 4);
		send_read(3);
		send_tri(3, 3, 4);
		send_item(ACT_UNUSED, 3, 16'h0000, 16'h0000, 16'h0000, 3, 3, 3);
		send_read(3);
		send_read(1023);
		send_load(0, 16'h0000, 16'h0000, 16'h0000);
		send_read(0);
		drain();
	endtask

	task automatic test_random_mesh(int items);
		int v;
		for (int n = 0; n < items; n++) begin
			v = $urandom_range(99);
			if (v < 20)
				send_load($urandom_range(63) * ($urandom_range(15) == 0 ? 16 : 1),
					rnd16(), rnd16(), rnd16());
			else if (v < 65)
				send_tri(loaded_vertex(), loaded_vertex(), loaded_vertex());
			else if (v < 97)
				send_read(loaded_vertex());
			else if (v < 99)
				send_read($urandom_range(NV - 1));
			else
				send_item(ACT_UNUSED, $urandom, rnd16(), rnd16(), rnd16(), $urandom,
					$urandom, $urandom);
		end
		drain();
	endtask

	initial begin
		mismatches = 0; checked = 0; idle_cycles = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		for (int i = 0; i < NV; i++) begin
			px[i] = 0; py[i] = 0; pz[i] = 0;
			acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0; loaded[i] = 0;
		end
		arst_n = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0; m_axis_tready = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		for (int i = 0; i < 64; i++)
			send_load(i, rnd16(), rnd16(), rnd16());
		test_extremes();
		test_random_mesh(400);
		send_idle_pct = 49;
		test_random_mesh(400);
		send_idle_pct = 0; recv_stall_pct = 49;
		test_random_mesh(400);
		send_idle_pct = 37; recv_stall_pct = 37;
		test_random_mesh(400);
		$display("covered loads, extreme-coordinate and repeated-corner triangles, reads");
		$display("%0d normals checked over four idling phases", checked);
		if (mismatches == 0 && normals_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
